// ===== design/segment_box_overlap_2d_assert.svh =====
// assertion macros for the segment box overlap block
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef SEGMENT_BOX_OVERLAP_2D_ASSERT_SVH
`define SEGMENT_BOX_OVERLAP_2D_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication under reset
`define SBO_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sbo assertion failed");
// next-cycle implication under reset
`define SBO_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sbo assertion failed");
`else
`define SBO_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SBO_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== design/sbo2d_pkg.sv =====
// shared types and region code constants for the segment box overlap block
// no dependencies
`default_nettype none
package sbo2d_pkg;

  // region code: top, bottom, right, left; zero means inside
  typedef logic [3:0] region_t;

  localparam region_t RC_INSIDE = 4'b0000;
  localparam region_t RC_TOP    = 4'b1000;
  localparam region_t RC_BOTTOM = 4'b0100;
  localparam region_t RC_RIGHT  = 4'b0010;
  localparam region_t RC_LEFT   = 4'b0001;

endpackage
`default_nettype wire

// ===== design/segment_box_overlap_2d.sv =====
`default_nettype none
// segment_box_overlap_2d: tells whether a line segment touches an
// axis-aligned box. Depends on sbo2d_pkg, sbo_region and the assert header.
//
// Input channel: in_valid_i / in_ready_o with the box corners and the two
// segment end points, all signed two's complement coordinates.
// Output channel: out_valid_o / out_ready_i with the one-bit overlap flag.
// A beat is taken on an edge where valid and ready are both high.
//
// Four register stages: region codes, corner choice and differences,
// four cross-product multiplies, then the signed compare into the output
// register. One beat can be taken in every cycle unless all stages are
// full and the receiver stalls; the multiply stage, one COORD_WIDTH+1
// square product per term, sets the cycle time.
// Each stage holds its own valid bit and moves on when the stage after it is
// empty or moving, so bubbles close up while the receiver stalls and the
// input keeps being taken until all four stages are full.
// Reset clears every valid bit; no beat is in flight afterwards.
`include "segment_box_overlap_2d_assert.svh"
module segment_box_overlap_2d #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] box_min_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_y_i,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          overlap_o
);
  import sbo2d_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  // stage valid bits and advance enables
  logic va_q, vb_q, vc_q, vd_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  assign rdy_d = !vd_q || out_ready_i;
  assign rdy_c = !vc_q || rdy_d;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  // stage a: region codes
  region_t c1, c2;
  region_t c1_q, c2_q;
  logic signed [W-1:0] px_q, py_q, qx_q, qy_q, x0_q, y0_q, x1_q, y1_q;

  sbo_region #(.COORD_WIDTH(COORD_WIDTH)) u_region_start (
    .x_i   (seg_start_x_i),
    .y_i   (seg_start_y_i),
    .lo_x_i(box_min_x_i),
    .lo_y_i(box_min_y_i),
    .hi_x_i(box_max_x_i),
    .hi_y_i(box_max_y_i),
    .code_o(c1)
  );

  sbo_region #(.COORD_WIDTH(COORD_WIDTH)) u_region_end (
    .x_i   (seg_end_x_i),
    .y_i   (seg_end_y_i),
    .lo_x_i(box_min_x_i),
    .lo_y_i(box_min_y_i),
    .hi_x_i(box_max_x_i),
    .hi_y_i(box_max_y_i),
    .code_o(c2)
  );

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      c1_q <= c1;
      c2_q <= c2;
      px_q <= seg_start_x_i;
      py_q <= seg_start_y_i;
      qx_q <= seg_end_x_i;
      qy_q <= seg_end_y_i;
      x0_q <= box_min_x_i;
      y0_q <= box_min_y_i;
      x1_q <= box_max_x_i;
      y1_q <= box_max_y_i;
    end
  end

  // stage b: early decisions, limiting corners and differences
  logic signed [W-1:0] rx, ry, lx, ly;
  logic                yes_b, no_b;
  region_t             cor;
  logic signed [DW-1:0] dx_d, dy_d, ax_d, ay_d, bx_d, by_d;
  logic signed [DW-1:0] dx_q, dy_q, ax_q, ay_q, bx_q, by_q;
  logic                yes_q, no_q;

  assign cor   = c1_q | c2_q;
  assign yes_b = (c1_q == RC_INSIDE) || (c2_q == RC_INSIDE) ||
                 (cor == (RC_TOP | RC_BOTTOM)) || (cor == (RC_LEFT | RC_RIGHT));
  assign no_b  = !yes_b && ((c1_q & c2_q) != RC_INSIDE);

  always_comb begin
    unique case (c1_q)
      RC_LEFT | RC_TOP: begin
        rx = x0_q; ry = y0_q; lx = x1_q; ly = y1_q;
      end
      RC_LEFT: begin
        rx = x0_q; ry = y0_q; lx = x0_q; ly = y1_q;
      end
      RC_LEFT | RC_BOTTOM: begin
        rx = x1_q; ry = y0_q; lx = x0_q; ly = y1_q;
      end
      RC_BOTTOM: begin
        rx = x1_q; ry = y0_q; lx = x0_q; ly = y0_q;
      end
      RC_RIGHT | RC_BOTTOM: begin
        rx = x1_q; ry = y1_q; lx = x0_q; ly = y0_q;
      end
      RC_RIGHT: begin
        rx = x1_q; ry = y1_q; lx = x1_q; ly = y0_q;
      end
      RC_RIGHT | RC_TOP: begin
        rx = x0_q; ry = y1_q; lx = x1_q; ly = y0_q;
      end
      default: begin
        rx = x0_q; ry = y1_q; lx = x1_q; ly = y1_q;
      end
    endcase
  end

  // sign-extended differences never overflow DW bits
  assign dx_d = {qx_q[W-1], qx_q} - {px_q[W-1], px_q};
  assign dy_d = {qy_q[W-1], qy_q} - {py_q[W-1], py_q};
  assign ax_d = {rx[W-1], rx} - {px_q[W-1], px_q};
  assign ay_d = {ry[W-1], ry} - {py_q[W-1], py_q};
  assign bx_d = {lx[W-1], lx} - {px_q[W-1], px_q};
  assign by_d = {ly[W-1], ly} - {py_q[W-1], py_q};

  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      ax_q  <= ax_d;
      ay_q  <= ay_d;
      bx_q  <= bx_d;
      by_q  <= by_d;
      yes_q <= yes_b;
      no_q  <= no_b;
    end
  end

  // stage c: the four cross-product terms
  logic signed [PW-1:0] p1_d, q1_d, p2_d, q2_d;
  logic signed [PW-1:0] p1_q, q1_q, p2_q, q2_q;
  logic                 yes_c_q, no_c_q;

  assign p1_d = dx_q * ay_q;
  assign q1_d = dy_q * ax_q;
  assign p2_d = bx_q * dy_q;
  assign q2_d = by_q * dx_q;

  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) begin
      p1_q    <= p1_d;
      q1_q    <= q1_d;
      p2_q    <= p2_d;
      q2_q    <= q2_d;
      yes_c_q <= yes_q;
      no_c_q  <= no_q;
    end
  end

  // stage d: sign tests and final answer into the output register
  logic signed [SW-1:0] d1, d2;
  logic                 np1, np2;
  logic                 overlap_d, overlap_q;

  assign d1  = {p1_q[PW-1], p1_q} - {q1_q[PW-1], q1_q};
  assign d2  = {p2_q[PW-1], p2_q} - {q2_q[PW-1], q2_q};
  assign np1 = d1[SW-1] || (d1 == '0);
  assign np2 = d2[SW-1] || (d2 == '0);
  assign overlap_d = yes_c_q || (!no_c_q && np1 && np2);

  always_ff @(posedge clk_i) begin
    if (rdy_d && vc_q) begin
      overlap_q <= overlap_d;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
    end
  end

  assign out_valid_o = vd_q;
  assign overlap_o   = overlap_q;

  // input only blocked when every stage holds a beat
  `SBO_ASSERT_IMP(a_full_when_blocked, clk_i, rst_ni, !in_ready_o, va_q && vb_q && vc_q && vd_q)
  // early yes and early no exclude each other
  `SBO_ASSERT_IMP(a_early_exclusive, clk_i, rst_ni, vb_q, !(yes_q && no_q))
  // an early yes always gives overlap
  `SBO_ASSERT_NXT(a_early_yes, clk_i, rst_ni, vc_q && rdy_d && yes_c_q, overlap_o)
  // a held product stage keeps its terms
  `SBO_ASSERT_NXT(a_hold_products, clk_i, rst_ni, vc_q && !rdy_c,
                  $stable(p1_q) && $stable(q1_q) && $stable(p2_q) && $stable(q2_q))

endmodule
`default_nettype wire

// ===== design/sbo_region.sv =====
// region code of one point against an axis-aligned box
// depends on sbo2d_pkg
`default_nettype none
module sbo_region #(
  parameter int COORD_WIDTH = 16
) (
  input  logic signed [COORD_WIDTH-1:0] x_i,
  input  logic signed [COORD_WIDTH-1:0] y_i,
  input  logic signed [COORD_WIDTH-1:0] lo_x_i,
  input  logic signed [COORD_WIDTH-1:0] lo_y_i,
  input  logic signed [COORD_WIDTH-1:0] hi_x_i,
  input  logic signed [COORD_WIDTH-1:0] hi_y_i,
  output sbo2d_pkg::region_t            code_o
);
  import sbo2d_pkg::*;

  region_t code_x;
  region_t code_y;

  // horizontal part, below-min test wins
  always_comb begin
    if (x_i < lo_x_i) begin
      code_x = RC_LEFT;
    end else if (x_i > hi_x_i) begin
      code_x = RC_RIGHT;
    end else begin
      code_x = RC_INSIDE;
    end
  end

  // vertical part, below-min test wins
  always_comb begin
    if (y_i < lo_y_i) begin
      code_y = RC_BOTTOM;
    end else if (y_i > hi_y_i) begin
      code_y = RC_TOP;
    end else begin
      code_y = RC_INSIDE;
    end
  end

  assign code_o = code_x | code_y;

endmodule
`default_nettype wire
